// ===== rtl/sitda_pkg.sv =====
// ----------------------------------------------------------------------------
// sitda_pkg
// Shared types and constants for the signed integer to decimal ASCII block.
// ----------------------------------------------------------------------------
package sitda_pkg;

    localparam int VALUE_W         = 32;
    localparam int DIGITS          = 10;
    localparam int DIGIT_IDX_W     = 4;
    localparam int STEPS_PER_STAGE = 4;
    localparam int DABBLE_STAGES   = VALUE_W / STEPS_PER_STAGE;

    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [7:0] ASCII_NINE  = 8'h39;
    localparam logic [7:0] ASCII_MINUS = 8'h2D;

    // Ten packed BCD digits, digit 0 is the units digit
    typedef logic [DIGITS-1:0][3:0] bcd_t;

    // One number in flight through the conversion pipeline
    typedef struct packed {
        logic                neg;
        bcd_t                bcd;
        logic [VALUE_W-1:0]  bin;
    } sitda_item_t;

endpackage

// ===== rtl/sitda_dabble_stage.sv =====
// ----------------------------------------------------------------------------
// sitda_dabble_stage
// One registered pipeline stage of the shift-and-add-3 binary to BCD
// conversion. Each stage consumes a fixed number of magnitude bits.
// ----------------------------------------------------------------------------
module sitda_dabble_stage
    import sitda_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  sitda_item_t in_item,
    output logic        out_valid,
    input  logic        out_ready,
    output sitda_item_t out_item
);

    logic        valid_reg;
    sitda_item_t item_reg;
    sitda_item_t item_next;
    logic [DIGITS*4+VALUE_W-2:0] shifted;

    // Advance whenever the stage is empty or its beat moves on
    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    // Adjust digits of five or more, then shift one magnitude bit in.
    // The top bit of the leading digit is always clear: the magnitude
    // fits in ten decimal digits.
    always_comb
    begin
        item_next = in_item;
        shifted   = '0;
        for (int s = 0; s < STEPS_PER_STAGE; s++)
        begin
            for (int d = 0; d < DIGITS; d++)
            begin
                if (item_next.bcd[d] >= 4'd5)
                begin
                    item_next.bcd[d] = item_next.bcd[d] + 4'd3;
                end
            end
            shifted       = {item_next.bcd[DIGITS-1][2:0], item_next.bcd[DIGITS-2:0],
                             item_next.bin};
            item_next.bcd = shifted[DIGITS*4+VALUE_W-2:VALUE_W-1];
            item_next.bin = {shifted[VALUE_W-2:0], 1'b0};
        end
    end

    // Hold valid under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // Capture payload on a moving beat
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= item_next;
        end
    end

endmodule

// ===== rtl/sitda_serializer.sv =====
// ----------------------------------------------------------------------------
// sitda_serializer
// Turns one converted number into a run of ASCII characters, sign first,
// most significant digit next, with the last flag on the units digit.
// ----------------------------------------------------------------------------
module sitda_serializer
    import sitda_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  sitda_item_t in_item,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_char,
    output logic        out_last
);

    logic                   busy_reg,     busy_next;
    logic                   neg_pend_reg, neg_pend_next;
    logic [DIGIT_IDX_W-1:0] pos_reg,      pos_next;
    bcd_t                   bcd_reg,      bcd_next;
    logic                   oval_reg,     oval_next;
    logic [7:0]             ochar_reg,    ochar_next;
    logic                   olast_reg,    olast_next;

    logic                   emit;
    logic                   finish;
    logic                   load;
    logic [DIGIT_IDX_W-1:0] lead;
    logic [3:0]             digit;

    assign out_valid = oval_reg;
    assign out_char  = ochar_reg;
    assign out_last  = olast_reg;

    // Find the leading nonzero digit; zero keeps the units digit
    always_comb
    begin
        lead = '0;
        for (int d = 1; d < DIGITS; d++)
        begin
            if (in_item.bcd[d] != 4'd0)
            begin
                lead = DIGIT_IDX_W'(d);
            end
        end
    end

    assign digit    = bcd_reg[pos_reg];
    assign emit     = busy_reg && (!oval_reg || out_ready);
    assign finish   = emit && !neg_pend_reg && (pos_reg == '0);
    assign in_ready = !busy_reg || finish;
    assign load     = in_valid && in_ready;

    // Step through the characters and load the next number on the last one or while idle
    always_comb
    begin
        busy_next     = busy_reg;
        neg_pend_next = neg_pend_reg;
        pos_next      = pos_reg;
        bcd_next      = bcd_reg;
        oval_next     = oval_reg;
        ochar_next    = ochar_reg;
        olast_next    = olast_reg;

        if (emit)
        begin
            oval_next = 1'b1;
            if (neg_pend_reg)
            begin
                ochar_next    = ASCII_MINUS;
                olast_next    = 1'b0;
                neg_pend_next = 1'b0;
            end
            else
            begin
                ochar_next = ASCII_ZERO + {4'd0, digit};
                olast_next = (pos_reg == '0);
                if (pos_reg != '0)
                begin
                    pos_next = pos_reg - 1'b1;
                end
            end
            if (finish)
            begin
                busy_next = 1'b0;
            end
        end
        else if (out_ready)
        begin
            oval_next = 1'b0;
        end

        if (load)
        begin
            busy_next     = 1'b1;
            neg_pend_next = in_item.neg;
            pos_next      = lead;
            bcd_next      = in_item.bcd;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            neg_pend_reg <= 1'b0;
            pos_reg      <= '0;
            oval_reg     <= 1'b0;
        end
        else
        begin
            busy_reg     <= busy_next;
            neg_pend_reg <= neg_pend_next;
            pos_reg      <= pos_next;
            oval_reg     <= oval_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        bcd_reg   <= bcd_next;
        ochar_reg <= ochar_next;
        olast_reg <= olast_next;
    end

endmodule

// ===== rtl/signed_int_to_decimal_ascii.sv =====
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Signed 32-bit integer to decimal ASCII text, one character per beat.
// ----------------------------------------------------------------------------
// Each input beat carries one two's complement 32-bit value. The block emits
// its decimal text most significant character first: a '-' for negative
// values, then the digits without leading zeros ("0" for zero), with tlast
// on the final character. The most negative value gives "-2147483648". A
// number has 1 to 11 characters; the character serializer sets the output
// rate and loads the next number as it emits the last character of the
// current one. Inputs enter a nine-stage pipeline (sign and magnitude, then
// eight shift-and-add-3 stages of four bits each), and the serializer adds
// two more registers: one holding the loaded number and one holding the
// output character.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii
    import sitda_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] char_code
    output logic        m_tlast    // is_last
);

    logic                        v0_reg;
    sitda_item_t                 item0_reg;
    sitda_item_t                 item0_next;
    logic                        rdy0;

    logic        [DABBLE_STAGES:0] v;
    logic        [DABBLE_STAGES:0] rdy;
    sitda_item_t [DABBLE_STAGES:0] item;

    // Sign and magnitude stage
    assign rdy0     = !v0_reg || rdy[0];
    assign s_tready = rdy0;

    always_comb
    begin
        item0_next     = '0;
        item0_next.neg = s_tdata[VALUE_W-1];
        item0_next.bin = s_tdata[VALUE_W-1] ? (VALUE_W'(0) - s_tdata) : s_tdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else if (rdy0)
        begin
            v0_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy0 && s_tvalid)
        begin
            item0_reg <= item0_next;
        end
    end

    assign v[0]    = v0_reg;
    assign item[0] = item0_reg;

    // Binary to BCD stages
    for (genvar g = 0; g < DABBLE_STAGES; g++)
    begin : g_dabble
        sitda_dabble_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (v[g]),
            .in_ready  (rdy[g]),
            .in_item   (item[g]),
            .out_valid (v[g+1]),
            .out_ready (rdy[g+1]),
            .out_item  (item[g+1])
        );
    end

    // Character output
    sitda_serializer u_ser (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v[DABBLE_STAGES]),
        .in_ready  (rdy[DABBLE_STAGES]),
        .in_item   (item[DABBLE_STAGES]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_char  (m_tdata),
        .out_last  (m_tlast)
    );

    // Every character is a minus sign or a decimal digit
    a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata == ASCII_MINUS ||
                      (m_tdata >= ASCII_ZERO && m_tdata <= ASCII_NINE)))
        else $error("character out of range");

    // A minus sign never ends a number
    a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata == ASCII_MINUS) |-> !m_tlast)
        else $error("minus sign flagged last");

    // An accepted beat lands in the first stage
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> v[0])
        else $error("accepted beat lost at entry");

    // An accepted minus sign is not followed directly by another minus sign
    a_minus_then_digit: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tdata == ASCII_MINUS) |=>
            (!m_tvalid || m_tdata != ASCII_MINUS))
        else $error("two minus signs in a row");

endmodule
